// ===== rtl/rotating_slot_message_pool_defines.svh =====
// Assertion macros shared by the rotating slot message pool RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ROTATING_SLOT_MESSAGE_POOL_DEFINES_SVH
`define ROTATING_SLOT_MESSAGE_POOL_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every clock while reset is released.
`define RSMP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rsmp assertion failed");
// Property checked on every clock, reset included.
`define RSMP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rsmp assertion failed");
`else
`define RSMP_ASSERT(lbl, clk, rst_n, prop)
`define RSMP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/rsmp_pkg.sv =====
// Package for the rotating slot message pool: sizes, codes and shared types.
// No dependencies.
package rsmp_pkg;

  localparam int SLOTS        = 16;
  localparam int PAYLOAD_BITS = 64;
  localparam int IO_BITS      = 64;
  localparam int SLOT_W       = $clog2(SLOTS);

  localparam logic [SLOTS-1:0] SLOT_ONE = {{(SLOTS-1){1'b0}}, 1'b1};

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_GET = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_EXEC,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic find;
    logic exec;
  } cmd_t;

endpackage

// ===== rtl/rsmp_in_if.sv =====
// Request channel of the rotating slot message pool.
// Depends on rsmp_pkg.
interface rsmp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [rsmp_pkg::IO_BITS-1:0] payload_in;

  modport source (output valid, output opcode, output payload_in, input ready);
  modport sink   (input valid, input opcode, input payload_in, output ready);
endinterface

// ===== rtl/rsmp_out_if.sv =====
// Result channel of the rotating slot message pool.
// Depends on rsmp_pkg.
interface rsmp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [rsmp_pkg::IO_BITS-1:0] payload_out;

  modport source (output valid, output ok, output payload_out, input ready);
  modport sink   (input valid, input ok, input payload_out, output ready);
endinterface

// ===== rtl/rotating_slot_message_pool.sv =====
// Rotating slot message pool: one transaction in, one result transaction out.
// A request is loaded in idle, then passes the find and execute states; the
// result is held in send until taken. No new request is accepted until then:
// the load/find/execute/send sequence shares one search unit and one store.
// Reset (rst_n low, synchronous): all slots empty, head at slot zero, idle.
module rotating_slot_message_pool (
  input  logic       clk,
  input  logic       rst_n,
  rsmp_in_if.sink    in_ch,
  rsmp_out_if.source out_ch
);

  // Command bundle from the sequencer to the slot datapath.
  rsmp_pkg::cmd_t cmd;

  // Sequencer: accept a request only when idle, then step the datapath
  // through search and update, and hold the result until it is taken.
  rsmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Datapath: capture the request, search the ring from the head with a
  // rotating priority encoder, then store or take out the slot payload.
  rsmp_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_opcode   (in_ch.opcode),
    .in_payload  (in_ch.payload_in),
    .out_ok      (out_ch.ok),
    .out_payload (out_ch.payload_out)
  );

endmodule

// ===== rtl/rsmp_ctrl.sv =====
// Sequencer of the rotating slot message pool: load, find, execute, send.
// Depends on rsmp_pkg.
module rsmp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output rsmp_pkg::cmd_t cmd
);

  rsmp_pkg::state_t state_r;
  rsmp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsmp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      rsmp_pkg::ST_IDLE: begin
        // Hold off requests while reset is applied.
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = rsmp_pkg::ST_FIND;
        end
      end
      rsmp_pkg::ST_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = rsmp_pkg::ST_EXEC;
      end
      rsmp_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = rsmp_pkg::ST_SEND;
      end
      rsmp_pkg::ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = rsmp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rsmp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/rsmp_datapath.sv =====
// Slot ring datapath: valid bits, payload store, head pointer, rotating
// priority search and result register. Depends on rsmp_pkg and the defines.
`include "rotating_slot_message_pool_defines.svh"
module rsmp_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rsmp_pkg::cmd_t               cmd,
  input  logic                         in_opcode,
  input  logic [rsmp_pkg::IO_BITS-1:0] in_payload,
  output logic                         out_ok,
  output logic [rsmp_pkg::IO_BITS-1:0] out_payload
);

  logic                                op_r;
  logic [rsmp_pkg::PAYLOAD_BITS-1:0]   pay_r;
  logic [rsmp_pkg::SLOTS-1:0]          valid_r;
  logic [rsmp_pkg::SLOT_W-1:0]         head_r;
  logic [rsmp_pkg::PAYLOAD_BITS-1:0]   mem_r [rsmp_pkg::SLOTS];
  logic                                found_r;
  logic [rsmp_pkg::SLOT_W-1:0]         idx_r;
  logic                                ok_r;
  logic [rsmp_pkg::PAYLOAD_BITS-1:0]   res_r;

  logic [rsmp_pkg::SLOTS-1:0]          cand;
  logic [rsmp_pkg::SLOTS-1:0]          rot;
  logic [rsmp_pkg::SLOTS-1:0]          low;
  logic [rsmp_pkg::SLOT_W-1:0]         hop;
  logic [rsmp_pkg::SLOT_W-1:0]         idx_nxt;
  logic                                add_hit;
  logic                                get_hit;

  // Rotate the candidate bits so the head lands at bit zero.
  always_comb begin
    logic [rsmp_pkg::SLOT_W:0] pos;
    cand = (op_r == rsmp_pkg::OP_GET) ? valid_r : ~valid_r;
    for (int i = 0; i < rsmp_pkg::SLOTS; i++) begin
      pos = {1'b0, head_r} + (rsmp_pkg::SLOT_W + 1)'(i);
      if (pos >= (rsmp_pkg::SLOT_W + 1)'(rsmp_pkg::SLOTS)) begin
        pos = pos - (rsmp_pkg::SLOT_W + 1)'(rsmp_pkg::SLOTS);
      end
      rot[i] = cand[pos[rsmp_pkg::SLOT_W-1:0]];
    end
  end

  // Isolate the lowest set bit and encode its distance from the head.
  always_comb begin
    logic [rsmp_pkg::SLOT_W:0] sum;
    low = rot & (~rot + rsmp_pkg::SLOT_ONE);
    hop = '0;
    for (int i = 0; i < rsmp_pkg::SLOTS; i++) begin
      if (low[i]) begin
        hop = hop | (rsmp_pkg::SLOT_W)'(i);
      end
    end
    sum = {1'b0, head_r} + {1'b0, hop};
    if (sum >= (rsmp_pkg::SLOT_W + 1)'(rsmp_pkg::SLOTS)) begin
      sum = sum - (rsmp_pkg::SLOT_W + 1)'(rsmp_pkg::SLOTS);
    end
    idx_nxt = sum[rsmp_pkg::SLOT_W-1:0];
  end

  assign add_hit = cmd.exec && found_r && (op_r == rsmp_pkg::OP_ADD);
  assign get_hit = cmd.exec && found_r && (op_r == rsmp_pkg::OP_GET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      head_r  <= '0;
    end else if (add_hit) begin
      valid_r[idx_r] <= 1'b1;
    end else if (get_hit) begin
      valid_r[idx_r] <= 1'b0;
      head_r         <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (add_hit) begin
      mem_r[idx_r] <= pay_r;
    end else if (get_hit) begin
      mem_r[idx_r] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      pay_r <= in_payload[rsmp_pkg::PAYLOAD_BITS-1:0];
    end
    if (cmd.find) begin
      found_r <= |rot;
      idx_r   <= idx_nxt;
    end
    if (cmd.exec) begin
      ok_r  <= found_r;
      res_r <= get_hit ? mem_r[idx_r] : '0;
    end
  end

  assign out_ok      = ok_r;
  assign out_payload = (rsmp_pkg::IO_BITS)'(res_r);

  `RSMP_ASSERT(a_add_fills_one, clk, rst_n,
    add_hit |=> ($countones(valid_r) == $past($countones(valid_r)) + 1))
  `RSMP_ASSERT(a_get_moves_head, clk, rst_n,
    get_hit |=> (head_r == $past(idx_r)) && !valid_r[$past(idx_r)])
  `RSMP_ASSERT(a_get_miss_empty, clk, rst_n,
    (cmd.exec && !found_r && (op_r == rsmp_pkg::OP_GET)) |-> (valid_r == '0))
  `RSMP_ASSERT(a_add_miss_full, clk, rst_n,
    (cmd.exec && !found_r && (op_r == rsmp_pkg::OP_ADD)) |-> (&valid_r))

endmodule
